/* rtl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the bitmap page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  // Default geometry of the page map.
  localparam int PAGE_COUNT_DEF    = 32768;
  localparam int PAGE_BITS_DEF     = 12;
  localparam int MAP_WORD_BITS_DEF = 64;

  // Bytes at the bottom of memory that are marked used at reset.
  localparam int RESERVED_BYTES = 4 * 1024 * 1024;

  // Field widths.
  localparam int ADDR_W     = 27;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_W-1:0] PAGE_LIMIT_RESET = 16'h8000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_PAGE   = 8'd0,
    REG_PAGE_LIMIT = 8'd1
  } reg_idx_t;

  // Request kind.
  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  // Result status.
  typedef enum logic [1:0] {
    STAT_ALLOCATED = 2'd0,
    STAT_NONE_FREE = 2'd1,
    STAT_FREED     = 2'd2,
    STAT_IGNORED   = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIV,
    S_RD,
    S_SCAN,
    S_FWR,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

/* rtl/bitmap_page_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over a used-bit map held in one RAM.
//
//   channel  direction  signals                      content
//   s_*      in         tvalid tready tuser tdata    request: action, free_address
//   m_*      out        tvalid tready tuser tdata    result: status, page_address
//   cfg_*    in         valid ready index data       register writes
//
// A request first splits its page number into map word and bit by a
// multiplication with the reciprocal of the map word width. A free then reads
// its map word and writes it back with the bit cleared; an allocation reads
// one map word per cycle until it finds a clear bit or passes the window end,
// and on a hit writes the word back with the bit set. S_OUT then loads the
// result register. Requests with an empty window or an out-of-range page skip
// the map. After reset a clearing pass writes one map word per cycle over all
// MAP_DEPTH words (512 by default) before the first request is taken. A stalled
// result holds the block in its last state until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int PAGE_COUNT    = PAGE_COUNT_DEF,
  parameter int PAGE_BITS     = PAGE_BITS_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Request channel.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [0:0]            s_tuser,   // [0] action
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] free_address
  // Result channel.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [1:0]            m_tuser,   // [1:0] status
  output logic      [OUT_DATA_W-1:0] m_tdata,   // [26:0] page_address, [31:27] zero
  // Configuration channel.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam int W         = MAP_WORD_BITS;
  localparam int MAP_DEPTH = (PAGE_COUNT + W - 1) / W;
  localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int BW        = $clog2(W);
  localparam int PN_W      = $clog2(PAGE_COUNT);
  localparam int HW        = PN_W + 1;
  localparam int CW        = (HW > CFG_W) ? HW : CFG_W;
  localparam int RESERVED  = RESERVED_BYTES >> PAGE_BITS;
  localparam int RES_LIM   = (RESERVED < PAGE_COUNT) ? RESERVED : PAGE_COUNT;
  localparam logic [CFG_W-1:0] LOW_PAGE_RESET = CFG_W'(RESERVED);

  // Reciprocal of the word width, exact for every page number of PN_W bits.
  localparam int     DIV_SH = PN_W + BW;
  localparam int     DM_W   = PN_W + 2;
  localparam int     PQ_W   = PN_W + DM_W;
  localparam longint DIV_M  = ((longint'(1) <<< DIV_SH) + longint'(W) - 1) / longint'(W);

  // Control and datapath registers.
  state_t             state, state_next;
  logic [CFG_W-1:0]   low_page;
  logic [CFG_W-1:0]   page_limit;
  logic [AW-1:0]      init_idx;
  logic [HW:0]        init_base;
  action_t            op;
  logic [PN_W-1:0]    page;
  logic [PN_W-1:0]    dq;
  logic [AW-1:0]      word_idx;
  logic [HW-1:0]      base;
  logic [BW-1:0]      start_bit;
  logic [HW-1:0]      hi;
  status_t            res_status;
  logic [ADDR_W-1:0]  res_addr;

  // Memory ports.
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [W-1:0]       mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [W-1:0]       mem_rdata;

  // Combinational helpers.
  logic               accept;
  logic               out_free;
  logic [CW-1:0]      hi_c;
  logic               empty_win;
  logic [IN_DATA_W-1:0] free_pg;
  logic               free_oob;
  logic [PQ_W-1:0]    div_prod;
  logic [PQ_W-1:0]    word_base;
  logic [BW-1:0]      div_rem;
  logic [HW-1:0]      lim;
  logic [W-1:0]       lo_mask;
  logic [W-1:0]       hi_mask;
  logic [W-1:0]       cand;
  logic [W-1:0]       hit_bit;
  logic               found;
  logic [BW-1:0]      hit_idx;
  logic [HW-1:0]      hit_page;
  logic [HW+PAGE_BITS-1:0] hit_byte;
  logic               last_word;
  logic [W-1:0]       init_word;
  logic [W-1:0]       free_mask;

  bpa_ram #(
    .WIDTH (W),
    .DEPTH (MAP_DEPTH),
    .ADDR_W(AW)
  ) u_map (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Allocation window and free range checks at request time.
  assign hi_c      = (CW'(page_limit) < CW'(PAGE_COUNT)) ? CW'(page_limit) : CW'(PAGE_COUNT);
  assign empty_win = CW'(low_page) >= hi_c;
  assign free_pg   = s_tdata >> PAGE_BITS;
  assign free_oob  = free_pg >= IN_DATA_W'(PAGE_COUNT);

  // Map word of the page by reciprocal multiplication, then the first page
  // of that word and the bit offset inside it.
  assign div_prod  = PQ_W'(page) * PQ_W'(DIV_M);
  assign word_base = PQ_W'(dq) * PQ_W'(W);
  assign div_rem   = BW'(PQ_W'(page) - word_base);

  // Candidate bits of the current map word and the lowest of them.
  assign lim = hi - base;
  always_comb begin
    for (int b = 0; b < W; b++) begin
      lo_mask[b] = BW'(b) >= start_bit;
      hi_mask[b] = HW'(b) < lim;
    end
  end
  assign cand    = ~mem_rdata & lo_mask & hi_mask;
  assign hit_bit = cand & (~cand + W'(1));
  assign found   = |cand;
  always_comb begin
    hit_idx = '0;
    for (int b = 0; b < W; b++) begin
      if (hit_bit[b]) begin
        hit_idx = hit_idx | BW'(b);
      end
    end
  end
  assign hit_page  = base + HW'(hit_idx);
  assign hit_byte  = {hit_page, {PAGE_BITS{1'b0}}};
  assign last_word = ((HW+1)'(base) + (HW+1)'(W)) >= (HW+1)'(hi);

  // Reset content of one map word during the clearing pass.
  always_comb begin
    for (int b = 0; b < W; b++) begin
      init_word[b] = (init_base + (HW+1)'(b)) < (HW+1)'(RES_LIM);
    end
  end

  assign free_mask = ~(W'(1) << start_bit);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (init_idx == AW'(MAP_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (s_tuser == ACT_ALLOC) begin
            state_next = empty_win ? S_OUT : S_DIV;
          end else begin
            state_next = free_oob ? S_OUT : S_DIV;
          end
        end
      end
      S_DIV: begin
        state_next = S_RD;
      end
      S_RD: begin
        state_next = (op == ACT_ALLOC) ? S_SCAN : S_FWR;
      end
      S_SCAN: begin
        if (found || last_word) begin
          state_next = S_OUT;
        end
      end
      S_FWR: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake and memory port controls.
  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = word_idx;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = word_idx + AW'(1);
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_idx;
        mem_wdata = init_word;
      end
      S_IDLE: begin
        s_tready = 1'b1;
      end
      S_RD: begin
        mem_re    = 1'b1;
        mem_raddr = dq[AW-1:0];
      end
      S_SCAN: begin
        if (found) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | hit_bit;
        end else begin
          mem_re = !last_word;
        end
      end
      S_FWR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata & free_mask;
      end
      default: begin
      end
    endcase
  end

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      low_page   <= LOW_PAGE_RESET;
      page_limit <= PAGE_LIMIT_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_LOW_PAGE:   low_page   <= cfg_data;
          REG_PAGE_LIMIT: page_limit <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Clearing pass counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_idx  <= '0;
      init_base <= '0;
    end else if (state == S_INIT) begin
      init_idx  <= init_idx + AW'(1);
      init_base <= init_base + (HW+1)'(W);
    end
  end

  // Request datapath: word split, scan position and pending result.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op       <= action_t'(s_tuser);
          hi       <= HW'(hi_c);
          res_addr <= '0;
          if (s_tuser == ACT_ALLOC) begin
            page       <= PN_W'(low_page);
            res_status <= STAT_NONE_FREE;
          end else begin
            page       <= PN_W'(free_pg);
            res_status <= free_oob ? STAT_IGNORED : STAT_FREED;
          end
        end
      end
      S_DIV: begin
        dq <= PN_W'(div_prod >> DIV_SH);
      end
      S_RD: begin
        word_idx  <= dq[AW-1:0];
        start_bit <= div_rem;
        base      <= HW'(word_base);
      end
      S_SCAN: begin
        if (found) begin
          res_status <= STAT_ALLOCATED;
          res_addr   <= ADDR_W'(hit_byte);
        end else if (!last_word) begin
          word_idx  <= word_idx + AW'(1);
          base      <= base + HW'(W);
          start_bit <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tuser <= res_status;
      m_tdata <= OUT_DATA_W'(res_addr);
    end
  end

`ifndef SYNTHESIS
  // The map is written only by the clearing pass, an allocation hit or a free.
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_INIT || state == S_SCAN || state == S_FWR))
    else $error("map written outside a write state");

  // A pending result is never overwritten while the output is stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && m_tvalid && !m_tready) |=> state == S_OUT)
    else $error("result left while output stalled");

  // The scan only looks at words that start inside the window.
  a_scan_window: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> base < hi)
    else $error("scan beyond window end");

  // Only a successful allocation carries a page address.
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != STAT_ALLOCATED) |-> m_tdata == '0)
    else $error("page address set on non-allocation result");
`endif

endmodule

`default_nettype wire

/* rtl/bpa_ram.sv */
// ----------------------------------------------------------------------------
// bpa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
